@@ sv/hbp_pkg.sv @@
// Shared types and constants for the half-word / byte packer.
package hbp_pkg;

    localparam int unsigned HW_W     = 18;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PHASE_W  = 4;
    localparam int unsigned BEATS    = 3;
    localparam int unsigned COUNT_W  = 2;
    localparam int unsigned TDATA_W  = 24;

    // Group lengths: half-words per group when packing, bytes when unpacking.
    localparam logic [PHASE_W-1:0] PACK_GLEN_DOUBLE   = 4'd4;
    localparam logic [PHASE_W-1:0] PACK_GLEN_SINGLE   = 4'd2;
    localparam logic [PHASE_W-1:0] UNPACK_GLEN_DOUBLE = 4'd9;
    localparam logic [PHASE_W-1:0] UNPACK_GLEN_SINGLE = 4'd5;

    // Register indexes on the configuration port.
    localparam logic REG_FORMAT_SELECT = 1'b0;
    localparam logic REG_DIRECTION     = 1'b1;

    localparam logic FMT_DOUBLE = 1'b0;
    localparam logic FMT_SINGLE = 1'b1;
    localparam logic DIR_PACK   = 1'b0;
    localparam logic DIR_UNPACK = 1'b1;

    typedef struct packed {
        logic format_select;
        logic direction;
    } hbp_cfg_t;

    // Beats produced by one input item, beat[0] goes out first.
    typedef struct packed {
        logic [COUNT_W-1:0]          count;
        logic [BEATS-1:0][HW_W-1:0]  beat;
    } hbp_result_t;

endpackage

@@ sv/hbp_core.sv @@
// Conversion logic with the group phase and residue registers.
module hbp_core
    import hbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  hbp_cfg_t          cfg,
    input  logic              clear,
    input  logic              accept,
    input  logic [HW_W-1:0]   value_in,
    input  logic              block_start,
    output hbp_result_t       result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [HW_W-1:0]    residue_reg, residue_next;

    logic [PHASE_W-1:0] p;
    logic [PHASE_W-1:0] p_inc;
    logic [PHASE_W-1:0] glen;
    logic [HW_W-1:0]    r;
    logic [HW_W-1:0]    w;
    logic [HW_W-1:0]    bx;
    logic [PHASE_W-1:0] new_phase;
    logic [HW_W-1:0]    new_residue;

    always_comb
    begin
        w           = value_in;
        bx          = {{(HW_W-BYTE_W){1'b0}}, value_in[BYTE_W-1:0]};
        p           = block_start ? '0 : phase_reg;
        r           = block_start ? '0 : residue_reg;
        result      = '0;
        new_phase   = phase_reg;
        new_residue = residue_reg;
        p_inc       = '0;

        if (cfg.direction == DIR_PACK)
        begin
            glen = (cfg.format_select == FMT_SINGLE) ? PACK_GLEN_SINGLE : PACK_GLEN_DOUBLE;
        end
        else
        begin
            glen = (cfg.format_select == FMT_SINGLE) ? UNPACK_GLEN_SINGLE
                                                     : UNPACK_GLEN_DOUBLE;
        end

        // A phase beyond the group restarts the group.
        if (p >= glen)
        begin
            p = '0;
            r = '0;
        end

        if (cfg.direction == DIR_PACK)
        begin
            if (p == 4'd0)
            begin
                result.count   = 2'd2;
                result.beat[0] = {10'b0, w[17:10]};
                result.beat[1] = {10'b0, w[9:2]};
                new_residue    = {16'b0, w[1:0]};
                new_phase      = 4'd1;
            end
            else if (cfg.format_select == FMT_SINGLE)
            begin
                result.count   = 2'd3;
                result.beat[0] = {10'b0, r[1:0], w[17:12]};
                result.beat[1] = {10'b0, w[11:4]};
                result.beat[2] = {14'b0, w[3:0]};
                new_residue    = '0;
                new_phase      = '0;
            end
            else
            begin
                case (p)
                    4'd1:
                    begin
                        result.count   = 2'd2;
                        result.beat[0] = {10'b0, r[1:0], w[17:12]};
                        result.beat[1] = {10'b0, w[11:4]};
                        new_residue    = {14'b0, w[3:0]};
                        new_phase      = 4'd2;
                    end
                    4'd2:
                    begin
                        result.count   = 2'd2;
                        result.beat[0] = {10'b0, r[3:0], w[17:14]};
                        result.beat[1] = {10'b0, w[13:6]};
                        new_residue    = {12'b0, w[5:0]};
                        new_phase      = 4'd3;
                    end
                    default:
                    begin
                        result.count   = 2'd3;
                        result.beat[0] = {10'b0, r[5:0], w[17:16]};
                        result.beat[1] = {10'b0, w[15:8]};
                        result.beat[2] = {10'b0, w[7:0]};
                        new_residue    = '0;
                        new_phase      = '0;
                    end
                endcase
            end
        end
        else
        begin
            case (p)
                4'd0: new_residue = bx << 10;
                4'd1: new_residue = r | (bx << 2);
                4'd2:
                begin
                    result.count   = 2'd1;
                    result.beat[0] = r | (bx >> 6);
                    new_residue    = (bx & 18'h0003F) << 12;
                end
                4'd3: new_residue = r | (bx << 4);
                4'd4:
                begin
                    result.count = 2'd1;
                    if (cfg.format_select == FMT_SINGLE)
                    begin
                        result.beat[0] = r | (bx & 18'h0000F);
                        new_residue    = '0;
                    end
                    else
                    begin
                        result.beat[0] = r | (bx >> 4);
                        new_residue    = (bx & 18'h0000F) << 14;
                    end
                end
                4'd5: new_residue = r | (bx << 6);
                4'd6:
                begin
                    result.count   = 2'd1;
                    result.beat[0] = r | (bx >> 2);
                    new_residue    = (bx & 18'h00003) << 16;
                end
                4'd7: new_residue = r | (bx << 8);
                default:
                begin
                    result.count   = 2'd1;
                    result.beat[0] = r | bx;
                    new_residue    = '0;
                end
            endcase
            p_inc     = p + 4'd1;
            new_phase = (p_inc >= glen) ? '0 : p_inc;
        end

        phase_next   = phase_reg;
        residue_next = residue_reg;
        if (clear)
        begin
            phase_next   = '0;
            residue_next = '0;
        end
        else if (accept)
        begin
            phase_next   = new_phase;
            residue_next = new_residue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            residue_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            residue_reg <= residue_next;
        end
    end

endmodule

@@ sv/hbp_outbuf.sv @@
// Buffer that holds up to three result beats, one sent per cycle unless stalled.
module hbp_outbuf
    import hbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  hbp_result_t         result,
    output logic                can_load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [HW_W-1:0]     m_value,
    output logic                m_tlast
);

    logic [COUNT_W-1:0]          cnt_reg, cnt_next;
    logic [BEATS-1:0][HW_W-1:0]  data_reg, data_next;
    logic                        pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_value  = data_reg[0];
    // A new item may load when the buffer is empty or its final beat leaves now.
    assign can_load = (cnt_reg == '0) || (m_tlast && m_tready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        data_next = data_reg;
        if (load)
        begin
            cnt_next  = result.count;
            data_next = result.beat;
        end
        else if (pop)
        begin
            cnt_next     = cnt_reg - 2'd1;
            data_next[0] = data_reg[1];
            data_next[1] = data_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ sv/halfword_byte_packer.sv @@
// The first result beat of an item appears in the cycle after its input is taken.
// Packing turns a half-word into two bytes, three for one that closes a group; the
// single result port sends one byte per cycle from the result buffer while m_tready
// is high. Unpacking takes one byte per cycle while the result port is not stalled.
// Reset (rst_n, asynchronous, active low) clears both registers, phase, residue and
// the result buffer; a register write also clears phase and residue.
module halfword_byte_packer
    import hbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // [17:0] value_in, [23:18] zero
    input  logic                s_tuser,   // [0] block_start
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [17:0] value_out, [23:18] zero
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic                cfg_data
);

    hbp_cfg_t     cfg_reg, cfg_next;
    hbp_result_t  result;
    logic         accept;
    logic         can_load;
    logic [HW_W-1:0] m_value;

    assign s_tready = can_load;
    assign accept   = s_tvalid && s_tready;
    assign m_tdata  = {{(TDATA_W-HW_W){1'b0}}, m_value};

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT_SELECT: cfg_next.format_select = cfg_data;
                REG_DIRECTION:     cfg_next.direction     = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hbp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clear       (cfg_we),
        .accept      (accept),
        .value_in    (s_tdata[HW_W-1:0]),
        .block_start (s_tuser),
        .result      (result)
    );

    hbp_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_value  (m_value),
        .m_tlast  (m_tlast)
    );

    // A packed half-word always yields at least two bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cfg_reg.direction == DIR_PACK) |=> (m_tvalid && !m_tlast))
        else $error("packed half-word did not start a multi-byte result");

    // A beat that is not the last of its item is followed by another one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("result run ended before its last beat");

    // No input beat is taken while more than one result beat is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input accepted with result beats still pending");

endmodule

@@ sim/halfword_byte_packer_chk.sv @@
// Checker for the half-word / byte packer: it predicts output beats and compares them.
module halfword_byte_packer_chk
    import hbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // [17:0] value_in, [23:18] zero
    input  logic                s_tuser,   // [0] block_start
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [TDATA_W-1:0]  m_tdata,   // [17:0] value_out, [23:18] zero
    input  logic                m_tlast,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic                cfg_data,
    output int unsigned         fail_count,
    output int unsigned         pending,
    output int unsigned         beats_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [HW_W-1:0] value;
        logic            last;
    } out_beat_t;

    out_beat_t              expected_beats[$];
    out_beat_t              want;
    logic                   fmt;
    logic                   dir;
    logic [PHASE_W-1:0]     phase;
    logic [HW_W-1:0]        residue;

    task automatic queue_beat(input logic [HW_W-1:0] value, input logic last);
        out_beat_t b;
        b.value = value;
        b.last  = last;
        expected_beats.push_back(b);
    endtask

    function automatic logic [HW_W-1:0] as_word(input logic [BYTE_W-1:0] b);
        return {{(HW_W-BYTE_W){1'b0}}, b};
    endfunction

    // Split one half-word into big-endian bytes, carrying leftover low bits.
    task automatic pack_halfword(input logic [HW_W-1:0] w);
        logic [PHASE_W-1:0] glen;
        glen = (fmt == FMT_SINGLE) ? PACK_GLEN_SINGLE : PACK_GLEN_DOUBLE;
        if (phase >= glen)
        begin
            phase   = '0;
            residue = '0;
        end
        if (phase == 4'd0)
        begin
            queue_beat(as_word(w[17:10]), 1'b0);
            queue_beat(as_word(w[9:2]), 1'b1);
            residue = {16'b0, w[1:0]};
            phase   = 4'd1;
        end
        else if (fmt == FMT_SINGLE)
        begin
            // The fifth byte of a single-format group holds only a nibble.
            queue_beat(as_word({residue[1:0], w[17:12]}), 1'b0);
            queue_beat(as_word(w[11:4]), 1'b0);
            queue_beat(as_word({4'b0, w[3:0]}), 1'b1);
            residue = '0;
            phase   = 4'd0;
        end
        else
        begin
            case (phase)
                4'd1:
                begin
                    queue_beat(as_word({residue[1:0], w[17:12]}), 1'b0);
                    queue_beat(as_word(w[11:4]), 1'b1);
                    residue = {14'b0, w[3:0]};
                    phase   = 4'd2;
                end
                4'd2:
                begin
                    queue_beat(as_word({residue[3:0], w[17:14]}), 1'b0);
                    queue_beat(as_word(w[13:6]), 1'b1);
                    residue = {12'b0, w[5:0]};
                    phase   = 4'd3;
                end
                default:
                begin
                    queue_beat(as_word({residue[5:0], w[17:16]}), 1'b0);
                    queue_beat(as_word(w[15:8]), 1'b0);
                    queue_beat(as_word(w[7:0]), 1'b1);
                    residue = '0;
                    phase   = 4'd0;
                end
            endcase
        end
    endtask

    // Collect one byte into the half-word under construction.
    task automatic unpack_byte(input logic [BYTE_W-1:0] b);
        logic [PHASE_W-1:0] glen;
        logic [HW_W-1:0]    wb;
        glen = (fmt == FMT_SINGLE) ? UNPACK_GLEN_SINGLE : UNPACK_GLEN_DOUBLE;
        wb   = as_word(b);
        if (phase >= glen)
        begin
            phase   = '0;
            residue = '0;
        end
        case (phase)
            4'd0: residue = wb << 10;
            4'd1: residue = residue | (wb << 2);
            4'd2:
            begin
                queue_beat(residue | (wb >> 6), 1'b1);
                residue = (wb & 18'h3F) << 12;
            end
            4'd3: residue = residue | (wb << 4);
            4'd4:
            begin
                if (fmt == FMT_SINGLE)
                begin
                    queue_beat(residue | (wb & 18'hF), 1'b1);
                    residue = '0;
                end
                else
                begin
                    queue_beat(residue | (wb >> 4), 1'b1);
                    residue = (wb & 18'hF) << 14;
                end
            end
            4'd5: residue = residue | (wb << 6);
            4'd6:
            begin
                queue_beat(residue | (wb >> 2), 1'b1);
                residue = (wb & 18'h3) << 16;
            end
            4'd7: residue = residue | (wb << 8);
            default:
            begin
                queue_beat(residue | wb, 1'b1);
                residue = '0;
            end
        endcase
        phase = phase + 4'd1;
        if (phase >= glen)
            phase = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt        = FMT_DOUBLE;
            dir        = DIR_PACK;
            phase      = '0;
            residue    = '0;
            fail_count = 0;
            beats_seen = 0;
            expected_beats.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_FORMAT_SELECT)
                    fmt = cfg_data;
                else
                    dir = cfg_data;
                phase   = '0;
                residue = '0;
            end
            if (m_tvalid && m_tready)
            begin
                beats_seen++;
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected output beat: value_out %05h last %0b",
                           m_tdata[HW_W-1:0], m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tdata[HW_W-1:0] !== want.value)
                    begin
                        $error("value_out: expected %05h, got %05h",
                               want.value, m_tdata[HW_W-1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                begin
                    phase   = '0;
                    residue = '0;
                end
                if (dir == DIR_UNPACK)
                    unpack_byte(s_tdata[BYTE_W-1:0]);
                else
                    pack_halfword(s_tdata[HW_W-1:0]);
            end
            pending = expected_beats.size();
        end
    end

endmodule

@@ sim/halfword_byte_packer_tb.sv @@
// Testbench top for the half-word / byte packer: clock, reset, stimulus and verdict.
module halfword_byte_packer_tb
    import hbp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 1000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;   // [17:0] value_in, [23:18] zero
    logic                s_tuser;   // [0] block_start
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;   // [17:0] value_out, [23:18] zero
    logic                m_tlast;
    logic                cfg_we;
    logic                cfg_index;
    logic                cfg_data;

    int unsigned         fail_count;
    int unsigned         pending;
    int unsigned         beats_seen;
    int unsigned         items_sent;
    int unsigned         reg_writes;
    int unsigned         quiet_cycles;
    logic                gaps_on;

    halfword_byte_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    halfword_byte_packer_chk chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .beats_seen (beats_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Each beat starts at a falling edge and ends at the falling edge after its handshake.
    task automatic send_item(input logic [HW_W-1:0] value, input logic block_start);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-HW_W){1'b0}}, value};
        s_tuser  <= block_start;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic index, input logic value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        reg_writes++;
        @(negedge clk);
    endtask

    // Unpacking may still be busy on a byte that yields nothing, so wait on once drained.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_mode(input logic fmt, input logic dir);
        wait_idle();
        write_reg(REG_FORMAT_SELECT, fmt);
        write_reg(REG_DIRECTION, dir);
    endtask

    // Sink side: a random stall before each output beat while gaps are on.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("halfword_byte_packer_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        logic [HW_W-1:0] value;
        logic            fmt;
        logic            dir;
        int              pick;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_FORMAT_SELECT;
        cfg_data     = 1'b0;
        gaps_on      = 1'b1;
        items_sent   = 0;
        reg_writes   = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Double-format packing: a full group, then a realign in the middle of one.
        set_mode(FMT_DOUBLE, DIR_PACK);
        send_item(18'h3FFFF, 1'b0);
        send_item(18'h00000, 1'b0);
        send_item(18'h2AAAA, 1'b0);
        send_item(18'h15555, 1'b0);
        send_item(18'h12345, 1'b0);
        send_item(18'h3FFFF, 1'b1);
        send_item(18'h0ABCD, 1'b0);

        // Single-format packing: the closing byte must come out with a zero high nibble.
        set_mode(FMT_SINGLE, DIR_PACK);
        send_item(18'h3FFFF, 1'b0);
        send_item(18'h3FFFF, 1'b0);
        send_item(18'h00000, 1'b0);
        send_item(18'h2AAAA, 1'b1);
        send_item(18'h1F00F, 1'b0);

        // Double-format unpacking with junk in the bits above the byte.
        set_mode(FMT_DOUBLE, DIR_UNPACK);
        send_item(18'h3FFFF, 1'b0);
        send_item(18'h3FF00, 1'b0);
        send_item(18'h155A5, 1'b0);
        send_item(18'h2AA5A, 1'b0);
        send_item(18'h000FF, 1'b0);
        send_item(18'h3C300, 1'b0);
        send_item(18'h0F0F0, 1'b0);
        send_item(18'h20081, 1'b0);
        send_item(18'h1007E, 1'b0);
        send_item(18'h000C3, 1'b1);

        // Single-format unpacking: the high nibble of the fifth byte is dropped.
        set_mode(FMT_SINGLE, DIR_UNPACK);
        send_item(18'h000FF, 1'b0);
        send_item(18'h3FF00, 1'b0);
        send_item(18'h000A5, 1'b0);
        send_item(18'h0005A, 1'b0);
        send_item(18'h3FFF3, 1'b0);

        // Random phases: all four modes first, then random ones; some phases run gap-free.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 4)
            begin
                fmt = 1'(ph % 2);
                dir = 1'(ph / 2);
            end
            else
            begin
                fmt = 1'($urandom_range(0, 1));
                dir = 1'($urandom_range(0, 1));
            end
            set_mode(fmt, dir);
            gaps_on = (ph % 3) != 2;
            repeat (26)
            begin
                value = 18'($urandom_range(0, 18'h3FFFF));
                pick  = int'($urandom_range(0, 15));
                if (pick == 0)
                    value = '0;
                else if (pick == 1)
                    value = '1;
                send_item(value, $urandom_range(0, 19) == 0);
            end
        end

        gaps_on = 1'b1;
        wait_idle();
        $display("Sent %0d input beats across %0d register writes in all four modes.",
                 items_sent, reg_writes);
        $display("Checked %0d output beats, %0d mismatches.", beats_seen, fail_count);
        if (fail_count == 0)
            $display("halfword_byte_packer_tb OK");
        else
            $display("halfword_byte_packer_tb NOT OK");
        $finish;
    end

endmodule
